[design/lxr_pkg.sv]
// Shared types, constants and result helpers for the expression lexer.
`default_nettype none

package lxr_pkg;

    // Default width of the position and length counters
    localparam int POS_BITS_DEF = 16;
    // Width of offsets and lengths as they leave the block
    localparam int OUT_BITS = 16;
    // Results one character can cause at most
    localparam int MAX_RESULTS = 3;
    localparam int CNT_BITS = 2;
    // Entries of the queue between front and back; a power of two
    localparam int QUEUE_DEPTH = 4;
    // Width of the master tdata bus: start, length, error code, zero pad
    localparam int TDATA_BITS = 40;
    localparam int TUSER_BITS = 4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_REAL = 2'd2,
        MODE_SYM  = 2'd3
    } lex_mode_t;

    typedef enum logic [2:0] {
        TT_NUM = 3'd0,
        TT_PL  = 3'd1,
        TT_PR  = 3'd2,
        TT_SEP = 3'd3,
        TT_OP  = 3'd4,
        TT_SYM = 3'd5
    } token_type_t;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_ALPHA = 3'd1,
        ERR_DOT   = 3'd2,
        ERR_CHAR  = 3'd3,
        ERR_PAREN = 3'd4,
        ERR_LONG  = 3'd5
    } error_code_t;

    typedef struct packed {
        token_type_t         token_type;
        logic [OUT_BITS-1:0] token_start;
        logic [OUT_BITS-1:0] token_length;
        logic                expr_end;
        error_code_t         error_code;
    } result_t;

    // All results caused by one character, slot 0 first
    typedef struct packed {
        logic [CNT_BITS-1:0]            count;
        result_t [MAX_RESULTS-1:0]      slot;
    } bundle_t;

    // Build a token word
    function automatic result_t make_token(input token_type_t ttype,
                                           input logic [OUT_BITS-1:0] start,
                                           input logic [OUT_BITS-1:0] length);
        result_t r;
        r.token_type   = ttype;
        r.token_start  = start;
        r.token_length = length;
        r.expr_end     = 1'b0;
        r.error_code   = ERR_OK;
        return r;
    endfunction

    // Build the closing status word
    function automatic result_t make_close(input error_code_t err);
        result_t r;
        r.token_type   = TT_NUM;
        r.token_start  = '0;
        r.token_length = '0;
        r.expr_end     = 1'b1;
        r.error_code   = err;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/lxr_front.sv]
// Front end: accepts characters, classifies them and tracks the lexer state.
`default_nettype none

module lxr_front #(
    parameter int POS_BITS = lxr_pkg::POS_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,     // ch
    input  wire logic             s_tlast,     // last
    input  wire logic             queue_full,
    output logic                  push,
    output lxr_pkg::bundle_t      push_bundle
);

    localparam int WIDE_BITS = (POS_BITS > lxr_pkg::OUT_BITS) ? POS_BITS : lxr_pkg::OUT_BITS;

    // Cut or extend a counter value to the output width
    function automatic logic [lxr_pkg::OUT_BITS-1:0] to_out(input logic [POS_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return w[lxr_pkg::OUT_BITS-1:0];
    endfunction

    lxr_pkg::lex_mode_t    mode_reg, mode_next;
    logic [POS_BITS-1:0]   tok_start_reg, tok_start_next;
    logic [POS_BITS-1:0]   tok_len_reg, tok_len_next;
    logic [POS_BITS-1:0]   char_pos_reg, char_pos_next;
    logic [15:0]           paren_reg, paren_next;
    logic                  discarding_reg, discarding_next;

    logic                  accept;
    logic                  is_digit, is_dot, is_alpha, is_space, is_oper, is_sep;
    logic                  cont, flush;
    lxr_pkg::error_code_t  err;
    lxr_pkg::token_type_t  flush_type;
    logic [lxr_pkg::CNT_BITS-1:0] cnt;
    lxr_pkg::result_t [lxr_pkg::MAX_RESULTS-1:0] slots;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the character
    assign is_digit = (s_tdata >= "0") && (s_tdata <= "9");
    assign is_dot   = (s_tdata == ".");
    assign is_alpha = ((s_tdata >= "a") && (s_tdata <= "z")) ||
                      ((s_tdata >= "A") && (s_tdata <= "Z")) || (s_tdata == "_");
    assign is_space = (s_tdata == 8'h20) || (s_tdata == 8'h09) || (s_tdata == 8'h0A) ||
                      (s_tdata == 8'h0D) || (s_tdata == 8'h0B) || (s_tdata == 8'h0C);
    assign is_oper  = (s_tdata == "+") || (s_tdata == "-") || (s_tdata == "*") ||
                      (s_tdata == "/") || (s_tdata == "^");
    assign is_sep   = (s_tdata == ",") || (s_tdata == ":") || (s_tdata == "|");

    // Work out the next state and the results of this character
    always_comb
    begin
        mode_next       = mode_reg;
        tok_start_next  = tok_start_reg;
        tok_len_next    = tok_len_reg;
        char_pos_next   = char_pos_reg;
        paren_next      = paren_reg;
        discarding_next = discarding_reg;
        err             = lxr_pkg::ERR_OK;
        cont            = 1'b0;
        flush           = 1'b0;
        flush_type      = (mode_reg == lxr_pkg::MODE_SYM) ? lxr_pkg::TT_SYM : lxr_pkg::TT_NUM;
        cnt             = '0;
        slots           = '0;

        if (discarding_reg)
        begin
            // Swallow the rest of a failed expression
            if (s_tlast)
                discarding_next = 1'b0;
        end
        else
        begin
            if (&char_pos_reg)
                err = lxr_pkg::ERR_LONG;
            else
            begin
                // Extend, end or reject the open token
                case (mode_reg)
                    lxr_pkg::MODE_INT:
                    begin
                        if (is_digit)
                            cont = 1'b1;
                        else if (is_dot)
                        begin
                            cont      = 1'b1;
                            mode_next = lxr_pkg::MODE_REAL;
                        end
                        else if (is_alpha)
                            err = lxr_pkg::ERR_ALPHA;
                        else
                            flush = 1'b1;
                    end
                    lxr_pkg::MODE_REAL:
                    begin
                        if (is_digit)
                            cont = 1'b1;
                        else if (is_dot)
                            err = lxr_pkg::ERR_DOT;
                        else if (is_alpha)
                            err = lxr_pkg::ERR_ALPHA;
                        else
                            flush = 1'b1;
                    end
                    lxr_pkg::MODE_SYM:
                    begin
                        if (is_alpha || is_digit || is_dot)
                            cont = 1'b1;
                        else
                            flush = 1'b1;
                    end
                    default:
                    begin
                        cont = 1'b0;
                    end
                endcase

                if (cont)
                    tok_len_next = tok_len_reg + POS_BITS'(1);

                if (flush)
                begin
                    slots[cnt] = lxr_pkg::make_token(flush_type, to_out(tok_start_reg),
                                                     to_out(tok_len_reg));
                    cnt        = cnt + lxr_pkg::CNT_BITS'(1);
                    mode_next  = lxr_pkg::MODE_IDLE;
                end

                // Start a token, emit a one-character token, skip white space or reject the character
                if (!cont && (err == lxr_pkg::ERR_OK))
                begin
                    if (is_space)
                    begin
                        cont = 1'b0;
                    end
                    else if (is_digit || is_dot)
                    begin
                        tok_start_next = char_pos_reg;
                        tok_len_next   = POS_BITS'(1);
                        mode_next      = is_dot ? lxr_pkg::MODE_REAL : lxr_pkg::MODE_INT;
                    end
                    else if (is_alpha)
                    begin
                        tok_start_next = char_pos_reg;
                        tok_len_next   = POS_BITS'(1);
                        mode_next      = lxr_pkg::MODE_SYM;
                    end
                    else if (s_tdata == "(")
                    begin
                        paren_next = paren_reg + 16'd1;
                        slots[cnt] = lxr_pkg::make_token(lxr_pkg::TT_PL, to_out(char_pos_reg),
                                                         lxr_pkg::OUT_BITS'(1));
                        cnt        = cnt + lxr_pkg::CNT_BITS'(1);
                    end
                    else if (s_tdata == ")")
                    begin
                        paren_next = paren_reg - 16'd1;
                        slots[cnt] = lxr_pkg::make_token(lxr_pkg::TT_PR, to_out(char_pos_reg),
                                                         lxr_pkg::OUT_BITS'(1));
                        cnt        = cnt + lxr_pkg::CNT_BITS'(1);
                    end
                    else if (is_sep)
                    begin
                        slots[cnt] = lxr_pkg::make_token(lxr_pkg::TT_SEP, to_out(char_pos_reg),
                                                         lxr_pkg::OUT_BITS'(1));
                        cnt        = cnt + lxr_pkg::CNT_BITS'(1);
                    end
                    else if (is_oper)
                    begin
                        slots[cnt] = lxr_pkg::make_token(lxr_pkg::TT_OP, to_out(char_pos_reg),
                                                         lxr_pkg::OUT_BITS'(1));
                        cnt        = cnt + lxr_pkg::CNT_BITS'(1);
                    end
                    else
                        err = lxr_pkg::ERR_CHAR;
                end

                if (err == lxr_pkg::ERR_OK)
                    char_pos_next = char_pos_reg + POS_BITS'(1);
            end

            // Close the expression on an error or at its last character
            if (err != lxr_pkg::ERR_OK)
            begin
                slots[cnt]      = lxr_pkg::make_close(err);
                cnt             = cnt + lxr_pkg::CNT_BITS'(1);
                discarding_next = !s_tlast;
            end
            else if (s_tlast)
            begin
                if (mode_next != lxr_pkg::MODE_IDLE)
                begin
                    slots[cnt] = lxr_pkg::make_token(
                        (mode_next == lxr_pkg::MODE_SYM) ? lxr_pkg::TT_SYM : lxr_pkg::TT_NUM,
                        to_out(tok_start_next), to_out(tok_len_next));
                    cnt        = cnt + lxr_pkg::CNT_BITS'(1);
                end
                slots[cnt] = lxr_pkg::make_close((paren_next != 16'd0) ? lxr_pkg::ERR_PAREN
                                                                       : lxr_pkg::ERR_OK);
                cnt        = cnt + lxr_pkg::CNT_BITS'(1);
            end

            if ((err != lxr_pkg::ERR_OK) || s_tlast)
            begin
                mode_next      = lxr_pkg::MODE_IDLE;
                tok_start_next = '0;
                tok_len_next   = '0;
                char_pos_next  = '0;
                paren_next     = '0;
            end
        end
    end

    assign push              = accept && (cnt != '0);
    assign push_bundle.count = cnt;
    assign push_bundle.slot  = slots;

    // Hold the lexer state; advance on each accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lxr_pkg::MODE_IDLE;
            tok_start_reg  <= '0;
            tok_len_reg    <= '0;
            char_pos_reg   <= '0;
            paren_reg      <= '0;
            discarding_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            tok_start_reg  <= tok_start_next;
            tok_len_reg    <= tok_len_next;
            char_pos_reg   <= char_pos_next;
            paren_reg      <= paren_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

`default_nettype wire

[design/lxr_queue.sv]
// Short queue of result bundles between the front and back ends.
`default_nettype none

module lxr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lxr_pkg::bundle_t  push_bundle,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output lxr_pkg::bundle_t       head
);

    localparam int PTR_BITS = $clog2(lxr_pkg::QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(lxr_pkg::QUEUE_DEPTH + 1);

    lxr_pkg::bundle_t    mem_reg [lxr_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == CNT_W'(lxr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the incoming bundle
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_bundle;
    end

endmodule

`default_nettype wire

[design/lxr_back.sv]
// Back end: walks each bundle one result per cycle into the output register, holding while m_tready is low.
`default_nettype none

module lxr_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             head_valid,
    input  wire lxr_pkg::bundle_t                 head,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lxr_pkg::TDATA_BITS-1:0]        m_tdata,  // token_start, token_length, error_code
    output logic [lxr_pkg::TUSER_BITS-1:0]        m_tuser,  // token_type, expr_end
    output logic                                  m_tlast   // run_last
);

    localparam int PAD_BITS = lxr_pkg::TDATA_BITS - 2 * lxr_pkg::OUT_BITS - 3;

    logic [lxr_pkg::CNT_BITS-1:0] idx_reg, idx_next;
    logic                         valid_reg, valid_next;
    lxr_pkg::result_t             res_reg;
    logic                         last_reg;
    logic                         load;
    logic                         is_final;

    // Take the next result whenever the output register is free
    assign load     = head_valid && (!valid_reg || m_tready);
    assign is_final = (idx_reg == (head.count - lxr_pkg::CNT_BITS'(1)));
    assign pop      = load && is_final;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_tready;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_final ? '0 : idx_reg + lxr_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.slot[idx_reg];
            last_reg <= is_final;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, res_reg.error_code, res_reg.token_length,
                       res_reg.token_start};
    assign m_tuser  = {res_reg.expr_end, res_reg.token_type};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[design/expression_lexer_core.sv]
// An accepted character's results are written into the queue and then loaded
//   into the output register. Throughput: one character per cycle while the
//   queue is not full; the 4-bundle queue absorbs the bursts of multi-word results.
// The output register sends one word per cycle while m_tready is high and results are queued.
// Reset (rst_n low, asynchronous) clears the lexer state, the queue and the
//   output valid; the block is ready for characters once reset is released.
`default_nettype none

module expression_lexer_core #(
    parameter int POS_BITS = lxr_pkg::POS_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // ch
    input  wire logic                           s_tlast,   // last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lxr_pkg::TDATA_BITS-1:0]      m_tdata,   // token_start, token_length, error_code
    output logic [lxr_pkg::TUSER_BITS-1:0]      m_tuser,   // token_type, expr_end
    output logic                                m_tlast    // run_last
);

    logic             push;
    lxr_pkg::bundle_t push_bundle;
    logic             queue_full;
    logic             head_valid;
    lxr_pkg::bundle_t head;
    logic             pop;

    lxr_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .queue_full  (queue_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    lxr_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .full        (queue_full),
        .head_valid  (head_valid),
        .head        (head)
    );

    lxr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
